// File: sv/dprs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dprs_pkg: shared definitions for the DNA pattern / reverse-complement search
// Widths, register indexes and the types that pass between the comparison
// cells and the top level.
// ----------------------------------------------------------------------------
package dprs_pkg;

    // Longest pattern, and therefore the number of comparison cells.
    localparam int MAX_PATTERN = 32;
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam int BASE_W      = 2;
    localparam int PAT_W       = 64;
    localparam int LEN_W       = 6;
    localparam int CNT_W       = 32;
    localparam int DATA_W      = 64;
    localparam int ADDR_W      = 5;
    localparam int REG_IDX_W   = 2;

    typedef logic [BASE_W-1:0] base_t;

    // Register indexes; each register sits at byte address 8 * index.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_PATTERN_BASES   = 2'd0,
        REG_PATTERN_LENGTH  = 2'd1,
        REG_FORWARD_ONLY    = 2'd2,
        REG_ANCHOR_AT_START = 2'd3
    } reg_idx_t;

    // What one cell compares its base against.
    typedef struct packed {
        logic  active;
        base_t fwd_base;
        base_t rev_base;
    } cell_cmp_t;

    // Per-cell comparison outcome.
    typedef struct packed {
        logic fwd_ok;
        logic rev_ok;
    } cell_res_t;

    // Base number idx of a packed pattern, first base in the lowest bits.
    function automatic base_t pattern_base(input logic [PAT_W-1:0] pat,
                                           input logic [IDX_W-1:0] idx);
        return pat[BASE_W*idx +: BASE_W];
    endfunction

    // Watson-Crick complement: A<->T, C<->G, which is 3 - code.
    function automatic base_t complement(input base_t b);
        return ~b;
    endfunction

endpackage
`default_nettype wire

// File: sv/dprs_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dprs_cell: one position of the base window
// Compares the base at its position with one forward and one reverse-
// complement pattern base and passes the base on to the next cell.
// ----------------------------------------------------------------------------
module dprs_cell
    import dprs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      shift_en,
    input  wire base_t     base_in,
    input  wire cell_cmp_t cmp,
    output base_t          base_out,
    output cell_res_t      res
);

    base_t tap_reg;

    // The base held here moves one cell further on every accepted transaction.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            tap_reg <= base_in;
        end
    end

    assign base_out   = tap_reg;
    assign res.fwd_ok = !cmp.active || (base_in == cmp.fwd_base);
    assign res.rev_ok = !cmp.active || (base_in == cmp.rev_base);

endmodule
`default_nettype wire

// File: sv/dna_pattern_revcomp_search.sv
`default_nettype none
// Latency: a sequence result is registered at the edge that accepts its last
//   base and is offered on the m_ channel from the following cycle.
// Throughput: one base per cycle, set by the combinational compare across the
//   row of window cells; input stalls only while a result waits downstream.
// Reset: aresetn is synchronous and active low; it clears the counters, the
//   per-sequence flags and the registers (pattern length returns to one).
// ----------------------------------------------------------------------------
// dna_pattern_revcomp_search: exact DNA pattern search with reverse complement
// Streams 2-bit bases through a row of comparison cells and reports, at the
// end of each sequence, whether the pattern and its reverse complement occur.
// ----------------------------------------------------------------------------
module dna_pattern_revcomp_search
    import dprs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Base input channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BASE_W-1:0] s_base,
    input  wire logic              s_last_base,
    // Sequence result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [CNT_W-1:0]       m_sequence_number,
    output logic                   m_forward_hit,
    output logic                   m_reverse_hit,
    output logic [CNT_W-1:0]       m_total_hits,
    // Register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    // ------------------------------------------------------------------
    // Configuration registers. The register index is taken from the
    // doubleword part of the address; the low three bits are ignored.
    // ------------------------------------------------------------------
    logic [PAT_W-1:0] pattern_bases_reg;
    logic [LEN_W-1:0] pattern_length_reg;
    logic             forward_only_reg;
    logic             anchor_at_start_reg;

    logic     cfg_write;
    reg_idx_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1 -: REG_IDX_W]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_bases_reg   <= '0;
            pattern_length_reg  <= LEN_W'(1);
            forward_only_reg    <= 1'b0;
            anchor_at_start_reg <= 1'b0;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_PATTERN_BASES:   pattern_bases_reg   <= pwdata[PAT_W-1:0];
                REG_PATTERN_LENGTH:  pattern_length_reg  <= pwdata[LEN_W-1:0];
                REG_FORWARD_ONLY:    forward_only_reg    <= pwdata[0];
                REG_ANCHOR_AT_START: anchor_at_start_reg <= pwdata[0];
                default:             pattern_bases_reg   <= pattern_bases_reg;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_PATTERN_BASES:   prdata = DATA_W'(pattern_bases_reg);
            REG_PATTERN_LENGTH:  prdata = DATA_W'(pattern_length_reg);
            REG_FORWARD_ONLY:    prdata = DATA_W'(forward_only_reg);
            REG_ANCHOR_AT_START: prdata = DATA_W'(anchor_at_start_reg);
            default:             prdata = '0;
        endcase
    end

    // Effective pattern length: zero behaves as one, anything above the cell
    // count behaves as the full row.
    logic [LEN_W-1:0] eff_len;

    always_comb begin
        priority if (pattern_length_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (pattern_length_reg > LEN_W'(MAX_PATTERN)) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = pattern_length_reg;
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The result register separates the two channels: a new
    // base is taken whenever the result slot is empty or being drained.
    // ------------------------------------------------------------------
    logic s_accept;
    logic m_valid_reg;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Row of window cells. Cell k sees the base that arrived k transactions
    // ago; cell 0 sees the incoming base. With a pattern of n bases, the
    // oldest base of the window (cell n-1) must equal pattern base 0, so
    // cell k checks forward pattern base n-1-k. The reverse complement
    // reverses the order again, so cell k simply checks the complement of
    // pattern base k. Cells at or beyond n are switched off.
    // ------------------------------------------------------------------
    base_t     taps [MAX_PATTERN+1];
    cell_res_t res  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] fwd_ok_vec;
    logic [MAX_PATTERN-1:0] rev_ok_vec;

    assign taps[0] = s_base;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        cell_cmp_t        cmp;
        logic [LEN_W-1:0] fwd_pos;

        assign fwd_pos      = eff_len - LEN_W'(k) - LEN_W'(1);
        assign cmp.active   = (eff_len > LEN_W'(k));
        assign cmp.fwd_base = pattern_base(pattern_bases_reg, fwd_pos[IDX_W-1:0]);
        assign cmp.rev_base = complement(pattern_base(pattern_bases_reg, IDX_W'(k)));

        dprs_cell u_cell (
            .aclk     (aclk),
            .shift_en (s_accept),
            .base_in  (taps[k]),
            .cmp      (cmp),
            .base_out (taps[k+1]),
            .res      (res[k])
        );

        assign fwd_ok_vec[k] = res[k].fwd_ok;
        assign rev_ok_vec[k] = res[k].rev_ok;
    end

    // ------------------------------------------------------------------
    // Per-sequence tracking. A window only counts once it holds bases of the
    // current sequence alone (bases seen at least n), or, in anchored mode,
    // exactly when the n-th base of the sequence arrives.
    // ------------------------------------------------------------------
    logic [LEN_W-1:0] bases_seen_reg, bases_seen_next;
    logic             fwd_seen_reg, fwd_seen_next;
    logic             rev_seen_reg, rev_seen_next;
    logic [CNT_W-1:0] seq_cnt_reg;
    logic [CNT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic             eligible;
    logic [1:0]       hit_add;
    logic [CNT_W:0]   hit_sum;

    assign bases_seen_next = (&bases_seen_reg) ? bases_seen_reg
                                               : bases_seen_reg + LEN_W'(1);
    assign eligible = anchor_at_start_reg ? (bases_seen_next == eff_len)
                                          : (bases_seen_next >= eff_len);

    assign fwd_seen_next = fwd_seen_reg || (eligible && (&fwd_ok_vec));
    assign rev_seen_next = rev_seen_reg ||
                           (eligible && !forward_only_reg && (&rev_ok_vec));

    // A sequence holding both forms adds two; the running count saturates.
    assign hit_add      = 2'(fwd_seen_next) + 2'(rev_seen_next);
    assign hit_sum      = {1'b0, hit_cnt_reg} + (CNT_W+1)'(hit_add);
    assign hit_cnt_next = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bases_seen_reg <= '0;
            fwd_seen_reg   <= 1'b0;
            rev_seen_reg   <= 1'b0;
            seq_cnt_reg    <= '0;
            hit_cnt_reg    <= '0;
        end else if (s_accept) begin
            if (s_last_base) begin
                bases_seen_reg <= '0;
                fwd_seen_reg   <= 1'b0;
                rev_seen_reg   <= 1'b0;
                seq_cnt_reg    <= seq_cnt_reg + CNT_W'(1);
                hit_cnt_reg    <= hit_cnt_next;
            end else begin
                bases_seen_reg <= bases_seen_next;
                fwd_seen_reg   <= fwd_seen_next;
                rev_seen_reg   <= rev_seen_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register: loaded by the transaction that closes a sequence.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] m_seq_reg;
    logic             m_fwd_reg;
    logic             m_rev_reg;
    logic [CNT_W-1:0] m_hits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept && s_last_base) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_last_base) begin
            m_seq_reg  <= seq_cnt_reg;
            m_fwd_reg  <= fwd_seen_next;
            m_rev_reg  <= rev_seen_next;
            m_hits_reg <= hit_cnt_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_sequence_number = m_seq_reg;
    assign m_forward_hit     = m_fwd_reg;
    assign m_reverse_hit     = m_rev_reg;
    assign m_total_hits      = m_hits_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_seq_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_last_base) |=>
            (bases_seen_reg == '0) && !fwd_seen_reg && !rev_seen_reg)
        else $error("sequence state not cleared after the last base");

    // A reverse hit found earlier in the sequence, before forward-only mode
    // was switched on, still stands.
    a_fwd_only_no_rev: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_last_base && forward_only_reg && !rev_seen_reg) |=>
            !m_reverse_hit)
        else $error("reverse hit reported in forward-only mode");

    a_hits_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (hit_cnt_reg >= $past(hit_cnt_reg)))
        else $error("running hit count decreased");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_accept)
        else $error("base accepted while a result is stalled");

endmodule
`default_nettype wire

// File: verif/dna_pattern_revcomp_search_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dna_pattern_revcomp_search_test: self-checking bench for the DNA pattern search
// A short table of directed base streams and register writes is followed by
// random phases of sequences, many carrying the pattern or its reverse complement.
// Every sequence report is compared with a local predictor of the search or a
// hand-written report, under changing settings and random idling on both channels.
// ----------------------------------------------------------------------------
module dna_pattern_revcomp_search_test;
    import dprs_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 5;
    // A report is registered at the edge that accepts its last base; the settle
    // cycles give ample margin before registers are touched or the run ends.
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 16;
    localparam int PHASE_BASES   = 102;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;

    localparam base_t BASE_A = 2'd0;
    localparam base_t BASE_C = 2'd1;
    localparam base_t BASE_G = 2'd2;
    localparam base_t BASE_T = 2'd3;

    // One end-of-sequence report, laid out like the result ports.
    typedef struct packed {
        logic [CNT_W-1:0] seq_no;
        logic             fwd;
        logic             rev;
        logic [CNT_W-1:0] total;
    } seq_report_t;

    // One row of the directed table: either a register write or one base,
    // optionally with a report written out by hand.
    typedef struct packed {
        logic              is_write;
        reg_idx_t          reg_sel;
        logic [DATA_W-1:0] value;
        base_t             b;
        logic              lst;
        logic              typed;
        seq_report_t       want;
    } stim_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [BASE_W-1:0] s_base = '0;
    logic              s_last_base = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [CNT_W-1:0]  m_sequence_number;
    logic              m_forward_hit;
    logic              m_reverse_hit;
    logic [CNT_W-1:0]  m_total_hits;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    dna_pattern_revcomp_search u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_base            (s_base),
        .s_last_base       (s_last_base),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_sequence_number (m_sequence_number),
        .m_forward_hit     (m_forward_hit),
        .m_reverse_hit     (m_reverse_hit),
        .m_total_hits      (m_total_hits),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #(HALF_PERIOD) aclk = 1'b1;
        #(HALF_PERIOD) aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Search predictor: its own copy of the registers and of the
    // per-sequence state, stepped once per accepted base transaction.
    // ------------------------------------------------------------------
    logic [PAT_W-1:0] cfg_pattern  = '0;
    logic [LEN_W-1:0] cfg_length   = 6'd1;
    logic             cfg_fwd_only = 1'b0;
    logic             cfg_anchor   = 1'b0;

    logic [PAT_W-1:0] win       = '0;  // newest base in the top two bits
    logic [LEN_W-1:0] seen      = '0;  // bases of the open sequence, stops at 63
    logic             fwd_flag  = 1'b0;
    logic             rev_flag  = 1'b0;
    logic [CNT_W-1:0] seq_count = '0;
    logic [CNT_W-1:0] hit_count = '0;

    // Expected reports, oldest first.
    seq_report_t pending_reports[$];

    // Hand-written report that travels with the base currently offered.
    logic        row_typed = 1'b0;
    seq_report_t row_want  = '0;

    int unsigned tx_gap_pct   = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned error_count  = 0;
    int unsigned bases_taken  = 0;
    int unsigned reports_seen = 0;
    int unsigned fwd_reports  = 0;
    int unsigned rev_reports  = 0;
    int unsigned quiet_cycles = 0;

    // A length of zero behaves as one and anything past the row of cells
    // behaves as the full row.
    function automatic int unsigned active_length(input logic [LEN_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_PATTERN)
            return MAX_PATTERN;
        return raw;
    endfunction

    // Reverse complement of the first n bases: the last base, complemented,
    // becomes the first.
    function automatic logic [PAT_W-1:0] reverse_complement(input logic [PAT_W-1:0] pat,
                                                            input int unsigned n);
        logic [PAT_W-1:0] r;
        r = '0;
        for (int i = 0; i < n; i++)
            r[2*i +: 2] = 2'd3 - pat[2*(n-1-i) +: 2];
        return r;
    endfunction

    task automatic advance_search(input base_t b, input logic lst,
                                  output logic closed, output seq_report_t rep);
        int unsigned      n;
        logic [PAT_W-1:0] mask;
        logic [PAT_W-1:0] fwd_pat;
        logic [PAT_W-1:0] recent;
        logic             eligible;
        logic [1:0]       add;
        n = active_length(cfg_length);
        mask = (n >= 32) ? '1 : ((64'd1 << (2 * n)) - 64'd1);
        fwd_pat = cfg_pattern & mask;
        win = {b, win[PAT_W-1:2]};
        if (seen != 6'd63)
            seen = seen + 6'd1;
        // Anchored mode only looks at the step where the first n bases have
        // just arrived.
        eligible = cfg_anchor ? (seen == n) : (seen >= n);
        if (eligible) begin
            recent = win >> (64 - 2 * n);
            if (recent == fwd_pat)
                fwd_flag = 1'b1;
            if (!cfg_fwd_only && recent == reverse_complement(fwd_pat, n))
                rev_flag = 1'b1;
        end
        closed = lst;
        rep = '0;
        if (lst) begin
            // Outside forward-only mode a palindromic hit sets both flags and so adds two.
            add = fwd_flag + rev_flag;
            hit_count = (hit_count > 32'hFFFF_FFFF - add) ? '1 : hit_count + add;
            rep = {seq_count, fwd_flag, rev_flag, hit_count};
            seq_count = seq_count + 1;
            win = '0;
            seen = '0;
            fwd_flag = 1'b0;
            rev_flag = 1'b0;
        end
    endtask

    task automatic record_error(input string what);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("[%0t] ERROR: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Scoreboard. Both channels are sampled at the rising edge. A report
    // always trails its last base, being registered at the edge that accepts
    // it, so checking the result channel before stepping the predictor is safe.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : scoreboard
        seq_report_t got;
        seq_report_t want;
        seq_report_t next_rep;
        logic        closed;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_sequence_number, m_forward_hit, m_reverse_hit, m_total_hits};
                reports_seen++;
                fwd_reports += m_forward_hit;
                rev_reports += m_reverse_hit;
                if (pending_reports.size() == 0) begin
                    record_error($sformatf("report for sequence %0d with none expected",
                                           got.seq_no));
                end else begin
                    want = pending_reports.pop_front();
                    if (got.seq_no !== want.seq_no || got.fwd !== want.fwd ||
                        got.rev !== want.rev || got.total !== want.total) begin
                        record_error($sformatf(
                            "report expected seq %0d fwd %0b rev %0b total %0d, got %0d %0b %0b %0d",
                            want.seq_no, want.fwd, want.rev, want.total,
                            got.seq_no, got.fwd, got.rev, got.total));
                    end
                end
            end
            if (s_valid && s_ready) begin
                bases_taken++;
                advance_search(s_base, s_last_base, closed, next_rep);
                if (closed)
                    pending_reports.push_back(row_typed ? row_want : next_rep);
            end
        end
    end

    // Watchdog: any stretch without a single transaction on either channel
    // that outlasts the limit means the block has hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The receiver stalls at random according to the current phase.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // ------------------------------------------------------------------
    // Drivers. All of them are entered and left at a falling edge, and none
    // assigns a signal at the edge where it returns, so back-to-back calls
    // never schedule two updates of one signal in the same step.
    // ------------------------------------------------------------------
    task automatic offer_base(input base_t b, input logic lst,
                              input logic typed, input seq_report_t want);
        while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_base      <= b;
        s_last_base <= lst;
        row_typed = typed;
        row_want  = want;
        @(posedge aclk);
        while (!(s_valid && s_ready))
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stop sending and let every outstanding report come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_reports.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // rising edge where the access cycle meets pready.
    task automatic write_register(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(8 * idx);
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        case (idx)
            REG_PATTERN_BASES:   cfg_pattern  = value;
            REG_PATTERN_LENGTH:  cfg_length   = value[LEN_W-1:0];
            REG_FORWARD_ONLY:    cfg_fwd_only = value[0];
            REG_ANCHOR_AT_START: cfg_anchor   = value[0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic stim_row_t base_row(input base_t b, input logic lst);
        stim_row_t row;
        row = '0;
        row.b = b;
        row.lst = lst;
        return row;
    endfunction

    // A closing base whose report is known by inspection.
    function automatic stim_row_t checked_row(input base_t b, input int unsigned seq_no,
                                              input logic f, input logic r,
                                              input int unsigned total);
        stim_row_t row;
        row = base_row(b, 1'b1);
        row.typed = 1'b1;
        row.want = {CNT_W'(seq_no), f, r, CNT_W'(total)};
        return row;
    endfunction

    function automatic stim_row_t write_row(input reg_idx_t idx, input logic [DATA_W-1:0] v);
        stim_row_t row;
        row = '0;
        row.is_write = 1'b1;
        row.reg_sel = idx;
        row.value = v;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        stim_row_t        rows[$];
        base_t            seq_bases[$];
        logic [PAT_W-1:0] pat;
        logic [PAT_W-1:0] motif;
        int unsigned      n;
        int unsigned      len_raw;
        int unsigned      seq_len;
        int unsigned      offset;
        int unsigned      sent;
        int unsigned      roll;
        logic             close_it;

        // Reset settings: a one-base pattern of A, so A is a forward hit
        // and T a reverse-complement hit.
        rows.push_back(checked_row(BASE_A, 0, 1'b1, 1'b0, 1));
        rows.push_back(checked_row(BASE_T, 1, 1'b0, 1'b1, 2));
        rows.push_back(base_row(BASE_C, 1'b0));
        rows.push_back(checked_row(BASE_G, 2, 1'b0, 1'b0, 2));
        // ACGT is its own reverse complement, so one sequence counts twice.
        rows.push_back(write_row(REG_PATTERN_BASES, 64'hE4));
        rows.push_back(write_row(REG_PATTERN_LENGTH, 64'd4));
        rows.push_back(base_row(BASE_A, 1'b0));
        rows.push_back(base_row(BASE_C, 1'b0));
        rows.push_back(base_row(BASE_G, 1'b0));
        rows.push_back(checked_row(BASE_T, 3, 1'b1, 1'b1, 4));
        // A sequence shorter than the pattern cannot hit.
        rows.push_back(base_row(BASE_A, 1'b0));
        rows.push_back(checked_row(BASE_C, 4, 1'b0, 1'b0, 4));
        // Anchored: the pattern sits at offset one, so it must be rejected.
        rows.push_back(write_row(REG_ANCHOR_AT_START, 64'd1));
        rows.push_back(base_row(BASE_T, 1'b0));
        rows.push_back(base_row(BASE_A, 1'b0));
        rows.push_back(base_row(BASE_C, 1'b0));
        rows.push_back(base_row(BASE_G, 1'b0));
        rows.push_back(checked_row(BASE_T, 5, 1'b0, 1'b0, 4));
        // Length zero acts as one; the pattern bits above it are ignored,
        // leaving a pattern of T. Forward only hides the A hit.
        rows.push_back(write_row(REG_FORWARD_ONLY, 64'd1));
        rows.push_back(write_row(REG_PATTERN_BASES, '1));
        rows.push_back(write_row(REG_PATTERN_LENGTH, 64'd0));
        rows.push_back(checked_row(BASE_A, 6, 1'b0, 1'b0, 4));
        rows.push_back(checked_row(BASE_T, 7, 1'b1, 1'b0, 5));
        // The largest length field clips to the full row of cells.
        rows.push_back(write_row(REG_PATTERN_LENGTH, 64'd63));
        rows.push_back(write_row(REG_PATTERN_BASES, 64'd0));
        rows.push_back(write_row(REG_FORWARD_ONLY, 64'd0));
        rows.push_back(write_row(REG_ANCHOR_AT_START, 64'd0));
        rows.push_back(base_row(BASE_A, 1'b0));
        rows.push_back(base_row(BASE_A, 1'b0));
        rows.push_back(checked_row(BASE_T, 8, 1'b0, 1'b0, 5));
        // Registers change inside an open sequence: the G is compared with
        // a pattern of A, the C that follows with a pattern of G.
        rows.push_back(write_row(REG_PATTERN_LENGTH, 64'd1));
        rows.push_back(base_row(BASE_G, 1'b0));
        rows.push_back(write_row(REG_PATTERN_BASES, 64'd2));
        rows.push_back(base_row(BASE_C, 1'b1));

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (rows[i]) begin
            if (rows[i].is_write) begin
                wait_drained();
                write_register(rows[i].reg_sel, rows[i].value);
            end else begin
                offer_base(rows[i].b, rows[i].lst, rows[i].typed, rows[i].want);
            end
        end

        // Random phases. Each one rewrites every register, then streams
        // sequences of which most carry the pattern or its reverse
        // complement, some at offset zero for the anchored mode.
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0: len_raw = 1;
                1: len_raw = MAX_PATTERN;
                2: len_raw = 63;
                3: len_raw = 0;
                default: begin
                    if (p % 3 == 0)
                        len_raw = 2 * $urandom_range(1, 3);
                    else if ($urandom_range(4) == 0)
                        len_raw = $urandom_range(63);
                    else
                        len_raw = $urandom_range(1, 6);
                end
            endcase
            pat = {$urandom, $urandom};
            if (p == 2)
                pat = '1;
            if (p == 5)
                pat = '0;
            n = active_length(len_raw[LEN_W-1:0]);
            // Some phases use a palindromic pattern, whose every hit is found on
            // both strands outside forward-only mode.
            if (p % 3 == 0 && n % 2 == 0) begin
                for (int i = 0; i < n / 2; i++)
                    pat[2*(n-1-i) +: 2] = 2'd3 - pat[2*i +: 2];
            end
            write_register(REG_PATTERN_BASES, pat);
            write_register(REG_PATTERN_LENGTH, DATA_W'(len_raw));
            write_register(REG_FORWARD_ONLY, DATA_W'((p >> 2) & 1));
            write_register(REG_ANCHOR_AT_START, DATA_W'((p >> 3) & 1));

            case (p % 4)
                0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_gap_pct = 49; rx_stall_pct = 0;  end
                2: begin tx_gap_pct = 0;  rx_stall_pct = 49; end
                default: begin tx_gap_pct = 18; rx_stall_pct = 18; end
            endcase

            sent = 0;
            while (sent < PHASE_BASES) begin
                roll = $urandom_range(99);
                if (roll < 4)
                    seq_len = $urandom_range(60, 70);  // drives the base count to its limit
                else if (roll < 20 && n > 1)
                    seq_len = $urandom_range(1, n - 1);
                else if (roll < 25)
                    seq_len = $urandom_range(1, 3);
                else
                    seq_len = n + $urandom_range(0, 8);
                seq_bases.delete();
                repeat (seq_len) seq_bases.push_back(base_t'($urandom_range(3)));
                roll = $urandom_range(99);
                if (seq_len >= n && roll < 65) begin
                    motif = (roll < 35) ? pat : reverse_complement(pat, n);
                    offset = ($urandom_range(1) == 0) ? 0 : $urandom_range(seq_len - n);
                    for (int i = 0; i < n; i++)
                        seq_bases[offset + i] = motif[2*i +: 2];
                end
                // Now and then the phase ends inside a sequence, so the next
                // phase finishes it under new register values.
                close_it = !(sent + seq_len >= PHASE_BASES && p != PHASES - 1 &&
                             $urandom_range(2) == 0);
                foreach (seq_bases[i])
                    offer_base(seq_bases[i], close_it && (i == seq_len - 1), 1'b0, '0);
                sent += seq_len;
            end
        end

        wait_drained();
        $display("Run covered %0d bases closing %0d sequences across %0d register phases,",
                 bases_taken, reports_seen, PHASES);
        $display("with %0d forward and %0d reverse-complement sequence hits reported.",
                 fwd_reports, rev_reports);
        if (pending_reports.size() != 0)
            record_error($sformatf("%0d reports never arrived", pending_reports.size()));
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d errors found", error_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
